// ===== rtl/i2cbb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared types and constants of the bit-banged I2C master waveform unit.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

  localparam int unsigned AddrW = 7;
  localparam int unsigned ByteW = 8;
  localparam logic [AddrW-1:0] AddrReset = 7'h20;

  // One frame byte request as it arrives on the input side.
  typedef struct packed {
    logic             op;
    logic [ByteW-1:0] data;
    logic             first;
    logic             last;
    logic [ByteW-1:0] read_bits;
  } i2cbb_in_t;

  // One line-setting step as it leaves on the result side.
  typedef struct packed {
    logic             scl;
    logic             sda;
    logic [ByteW-1:0] read_byte;
    logic             last_step;
  } i2cbb_out_t;

  // Operation codes of the op field.
  localparam logic OpWrite = 1'b0;
  localparam logic OpRead  = 1'b1;

  // Phases of the line sequencer.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_ADDR,
    PH_WR,
    PH_RD_REL,
    PH_RD_BITS,
    PH_RD_ACK,
    PH_STOP
  } i2cbb_phase_e;

  // Classified request handed from the front end to the sequencer.
  typedef struct packed {
    i2cbb_phase_e     entry;
    logic             op;
    logic             last;
    logic [ByteW-1:0] addr_byte;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] read_bits;
  } i2cbb_cmd_t;

endpackage

// ===== rtl/i2cbb_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cbb_fifo
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module i2cbb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // The fill count never exceeds the depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("fifo count beyond depth");

  // Pointers agree with the count: equal pointers mean empty or full.
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) |-> (empty_o || full_o))
    else $error("fifo pointers disagree with count");

  // A push into a non-full queue always leaves it non-empty.
  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> !empty_o)
    else $error("fifo lost a pushed entry");

endmodule

// ===== rtl/i2cbb_front.sv =====
// ----------------------------------------------------------------------------
// i2cbb_front
// Holds the slave address register and classifies each incoming frame byte.
// ----------------------------------------------------------------------------
module i2cbb_front
  import i2cbb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_wdata_i,
  input  i2cbb_in_t        item_i,
  output i2cbb_cmd_t       cmd_o
);

  logic [AddrW-1:0] slave_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= AddrReset;
    end else if (cfg_we_i) begin
      slave_addr_q <= cfg_wdata_i;
    end
  end

  // The first phase depends on whether a start is needed and on the direction.
  always_comb begin
    cmd_o.op        = item_i.op;
    cmd_o.last      = item_i.last;
    cmd_o.addr_byte = {slave_addr_q, item_i.op};
    cmd_o.data      = item_i.data;
    cmd_o.read_bits = item_i.read_bits;
    if (item_i.first) begin
      cmd_o.entry = PH_START;
    end else if (item_i.op == OpRead) begin
      cmd_o.entry = PH_RD_REL;
    end else begin
      cmd_o.entry = PH_WR;
    end
  end

endmodule

// ===== rtl/i2cbb_seq.sv =====
// ----------------------------------------------------------------------------
// i2cbb_seq
// Line sequencer: turns queued requests into one SCL/SDA step per cycle while the step queue is not full.
// ----------------------------------------------------------------------------
module i2cbb_seq
  import i2cbb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  i2cbb_cmd_t cmd_i,
  input  logic       cmd_empty_i,
  output logic       cmd_pop_o,
  output i2cbb_out_t res_o,
  output logic       res_push_o,
  input  logic       res_full_i
);

  i2cbb_phase_e     phase_q, phase_d, next_ph;
  logic [1:0]       sub_q, sub_d;
  logic [3:0]       bit_q, bit_d;
  logic [ByteW-1:0] sh_q, sh_d;
  i2cbb_cmd_t       cmd_q, cmd_d;
  logic             scl_q, scl_d, sda_q, sda_d;
  logic             step_en, ph_end, fin;

  assign step_en    = (phase_q != PH_IDLE) && !res_full_i;
  assign res_push_o = step_en;

  always_comb begin
    phase_d   = phase_q;
    sub_d     = sub_q + 2'd1;
    bit_d     = bit_q;
    sh_d      = sh_q;
    cmd_d     = cmd_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    ph_end    = 1'b0;
    next_ph   = PH_IDLE;
    cmd_pop_o = 1'b0;

    case (phase_q)
      PH_START: begin
        case (sub_q)
          2'd0:    sda_d = 1'b1;
          2'd1:    scl_d = 1'b1;
          2'd2:    sda_d = 1'b0;
          default: begin
            scl_d  = 1'b0;
            ph_end = 1'b1;
          end
        endcase
        next_ph = PH_ADDR;
      end
      PH_ADDR, PH_WR: begin
        if (!bit_q[3]) begin
          case (sub_q)
            2'd0:    sda_d = sh_q[ByteW-1];
            2'd1:    scl_d = 1'b1;
            default: begin
              scl_d = 1'b0;
              sh_d  = {sh_q[ByteW-2:0], 1'b0};
              bit_d = bit_q + 4'd1;
              sub_d = 2'd0;
            end
          endcase
        end else begin
          // Acknowledge clock; SDA keeps the last data bit.
          if (sub_q == 2'd0) begin
            scl_d = 1'b1;
          end else begin
            scl_d  = 1'b0;
            ph_end = 1'b1;
          end
        end
        if (phase_q == PH_ADDR) begin
          next_ph = (cmd_q.op == OpRead) ? PH_RD_REL : PH_WR;
        end else begin
          next_ph = cmd_q.last ? PH_STOP : PH_IDLE;
        end
      end
      PH_RD_REL: begin
        sda_d   = 1'b1;
        ph_end  = 1'b1;
        next_ph = PH_RD_BITS;
      end
      PH_RD_BITS: begin
        if (sub_q == 2'd0) begin
          scl_d = 1'b1;
        end else begin
          scl_d  = 1'b0;
          bit_d  = bit_q + 4'd1;
          sub_d  = 2'd0;
          ph_end = (bit_q == 4'd7);
        end
        next_ph = PH_RD_ACK;
      end
      PH_RD_ACK: begin
        case (sub_q)
          2'd0:    sda_d = 1'b0;
          2'd1:    scl_d = 1'b1;
          2'd2:    scl_d = 1'b0;
          default: begin
            sda_d  = 1'b1;
            ph_end = 1'b1;
          end
        endcase
        next_ph = cmd_q.last ? PH_STOP : PH_IDLE;
      end
      PH_STOP: begin
        case (sub_q)
          2'd0:    scl_d = 1'b0;
          2'd1:    sda_d = 1'b0;
          2'd2:    scl_d = 1'b1;
          default: begin
            sda_d  = 1'b1;
            ph_end = 1'b1;
          end
        endcase
        next_ph = PH_IDLE;
      end
      default: begin
        sub_d = sub_q;
      end
    endcase

    fin = ph_end && (next_ph == PH_IDLE);

    res_o.scl       = scl_d;
    res_o.sda       = sda_d;
    res_o.last_step = fin;
    res_o.read_byte = (fin && cmd_q.op == OpRead) ? cmd_q.read_bits : '0;

    if (!step_en) begin
      // Hold everything while stalled; an idle sequencer may still load.
      phase_d = phase_q;
      sub_d   = sub_q;
      bit_d   = bit_q;
      sh_d    = sh_q;
      scl_d   = scl_q;
      sda_d   = sda_q;
      ph_end  = 1'b0;
      fin     = 1'b0;
    end else if (ph_end) begin
      phase_d = next_ph;
      sub_d   = 2'd0;
      bit_d   = '0;
    end

    // The next request is taken when the current one finishes or none is active.
    if (((phase_q == PH_IDLE) || fin) && !cmd_empty_i) begin
      cmd_pop_o = 1'b1;
      cmd_d     = cmd_i;
      phase_d   = cmd_i.entry;
      sub_d     = 2'd0;
      bit_d     = '0;
    end

    if (phase_d != phase_q || cmd_pop_o) begin
      if (phase_d == PH_ADDR) begin
        sh_d = cmd_d.addr_byte;
      end else if (phase_d == PH_WR) begin
        sh_d = cmd_d.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      sub_q   <= '0;
      bit_q   <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else begin
      phase_q <= phase_d;
      sub_q   <= sub_d;
      bit_q   <= bit_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    cmd_q <= cmd_d;
  end

  // No step is produced while the result queue is full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("step pushed into full result queue");

  // A request is only taken from a non-empty command queue.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !cmd_empty_i)
    else $error("pop from empty command queue");

  // SDA stays released while the slave drives the read bits.
  a_rd_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RD_BITS) |-> sda_q)
    else $error("SDA driven during read bits");

  // The bit counter never runs past the acknowledge slot.
  a_bit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= 4'd8)
    else $error("bit counter out of range");

  // Lines only move on a produced step.
  a_lines_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_push_o |=> ($stable(scl_q) && $stable(sda_q)))
    else $error("line level changed without a step");

endmodule

// ===== rtl/i2c_master_bitbang_waveform_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bitbang_waveform_unit
// Bit-banged I2C master that expands frame byte requests into line steps.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  ---------------------------------
//  request   in         push / full         item_i  (op, data, first, last,
//                                                     read_bits)
//  step      out        empty / pop          step_o  (scl, sda, read_byte,
//                                                     last_step)
//  config    in         cfg_we_i             cfg_wdata_i (slave address)
//
//  A request is expanded in the sequencer into line steps, phase by phase:
//  start, address or write byte, read byte, stop. A request is accepted
//  whenever the command queue has room, so the next request waits in the
//  queue while the current one is expanded.
//  The sequencer stalls only when the step queue is full; pop may be held
//  low for any time without losing a step.
//  Reset leaves both lines released high and the slave address at 0x20.
// ----------------------------------------------------------------------------
module i2c_master_bitbang_waveform_unit
  import i2cbb_pkg::*;
#(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned ResDepth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration write port for the slave address.
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_wdata_i,
  // Request side.
  input  logic             push,
  output logic             full,
  input  i2cbb_in_t        item_i,
  // Step side.
  output logic             empty,
  input  logic             pop,
  output i2cbb_out_t       step_o
);

  localparam int unsigned CmdW = $bits(i2cbb_cmd_t);
  localparam int unsigned ResW = $bits(i2cbb_out_t);

  i2cbb_cmd_t cmd_in, cmd_out;
  i2cbb_out_t res_in;
  logic       cmd_empty, cmd_pop;
  logic       res_full, res_push;
  logic [CmdW-1:0] cmd_rdata;
  logic [ResW-1:0] res_rdata;

  // Front end: address register and request classification.
  i2cbb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_o       (cmd_in)
  );

  // Command queue decouples request acceptance from the line sequencer.
  i2cbb_fifo #(
    .Width (CmdW),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign cmd_out = i2cbb_cmd_t'(cmd_rdata);

  // Back end: produces one line step per cycle while the step queue has room.
  i2cbb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Step queue is the output register stage; it lets pop stall freely.
  i2cbb_fifo #(
    .Width (ResW),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign step_o = i2cbb_out_t'(res_rdata);

endmodule
